@@ hdl/twio_pkg.sv @@
// ----------------------------------------------------------------------------
// twio_pkg
// shared constants, codes and types of the two wheel imu odometry block
// ----------------------------------------------------------------------------
package twio_pkg;

  // cordic iterations and fraction bits of the position
  localparam int CORDIC_STEPS = 16;
  localparam int FRAC_BITS    = 16;
  localparam int IDX_W        = $clog2(CORDIC_STEPS);

  // register map
  localparam int   CFG_ADDR_W    = 3;
  localparam logic REG_LPD_IDX   = 1'b0;
  localparam logic [31:0] LPD_RESET = 32'd292824;

  // cos(45 deg) in q30, gain correction in q15
  localparam logic [29:0] C45     = 30'd759250125;
  localparam logic [14:0] GAIN    = 15'd19898;
  localparam int          GAIN_SH = 15;
  localparam int          GHI_UP  = 32 - GAIN_SH;

  // widths of the datapath
  localparam int MQ_W  = 48;              // body delta in q.16 degrees
  localparam int SH    = 40 - FRAC_BITS;  // drop after length scaling
  localparam int UP    = FRAC_BITS - 8;   // lift of the upper partial product
  localparam int SUM_W = MQ_W + UP + 1;
  localparam int CAP_W = 47;
  localparam logic [CAP_W-1:0] BODY_CAP = {1'b1, {(CAP_W-1){1'b0}}};
  localparam int XY_W  = 50;
  localparam int Z_W   = 34;
  localparam int POS_W = 48;
  localparam int D_W   = 52;

  typedef enum logic [3:0] {
    S_IDLE, S_DIFF, S_MAG, S_MQ, S_PLO, S_PHI, S_SUM, S_SAT,
    S_PREP, S_ROT, S_GLO, S_GHI, S_GSUM, S_GADD, S_DONE
  } twio_state_t;

  typedef enum logic [3:0] {
    DP_NOP, DP_LOAD, DP_DIFF, DP_MAG, DP_MQ, DP_PLO, DP_PHI, DP_SUM,
    DP_SAT, DP_PREP, DP_ROT, DP_GLO, DP_GHI, DP_GSUM, DP_GADD, DP_COMMIT
  } twio_op_t;

  typedef struct packed {
    twio_op_t         op;
    logic             ch;   // 0: x / u channel, 1: y / v channel
    logic [IDX_W-1:0] idx;  // cordic iteration
  } twio_cmd_t;

  typedef struct packed {
    logic start;            // item held in the datapath is a start item
  } twio_status_t;

  // atan(2^-i) in 2^-32 turn
  function automatic logic [31:0] twio_atan(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:    r = 32'd536870912;
      5'd1:    r = 32'd316933406;
      5'd2:    r = 32'd167458907;
      5'd3:    r = 32'd85004756;
      5'd4:    r = 32'd42667331;
      5'd5:    r = 32'd21354465;
      5'd6:    r = 32'd10679838;
      5'd7:    r = 32'd5340245;
      5'd8:    r = 32'd2670163;
      5'd9:    r = 32'd1335087;
      5'd10:   r = 32'd667544;
      5'd11:   r = 32'd333772;
      5'd12:   r = 32'd166886;
      5'd13:   r = 32'd83443;
      5'd14:   r = 32'd41722;
      5'd15:   r = 32'd20861;
      5'd16:   r = 32'd10430;
      5'd17:   r = 32'd5215;
      5'd18:   r = 32'd2608;
      5'd19:   r = 32'd1304;
      5'd20:   r = 32'd652;
      5'd21:   r = 32'd326;
      5'd22:   r = 32'd163;
      5'd23:   r = 32'd81;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

@@ hdl/twio_ctrl.sv @@
// ----------------------------------------------------------------------------
// twio_ctrl
// sequencer of the odometry datapath and owner of the output valid
// ----------------------------------------------------------------------------
module twio_ctrl import twio_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  output logic         m_tvalid,
  input  logic         m_tready,
  input  twio_status_t status,
  output twio_cmd_t    cmd
);

  twio_state_t      state, state_next;
  logic             ch, ch_next;
  logic [IDX_W-1:0] idx, idx_next;
  logic             out_valid, out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ch        <= 1'b0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      ch        <= ch_next;
      idx       <= idx_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    ch_next        = ch;
    idx_next       = idx;
    out_valid_next = out_valid && !m_tready;
    cmd.op         = DP_NOP;
    cmd.ch         = ch;
    cmd.idx        = idx;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.op     = DP_LOAD;
          state_next = S_DIFF;
        end
      end
      S_DIFF: begin
        cmd.op     = DP_DIFF;
        ch_next    = 1'b0;
        state_next = status.start ? S_DONE : S_MAG;
      end
      S_MAG: begin
        cmd.op     = DP_MAG;
        state_next = S_MQ;
      end
      S_MQ: begin
        cmd.op     = DP_MQ;
        state_next = S_PLO;
      end
      S_PLO: begin
        cmd.op     = DP_PLO;
        state_next = S_PHI;
      end
      S_PHI: begin
        cmd.op     = DP_PHI;
        state_next = S_SUM;
      end
      S_SUM: begin
        cmd.op     = DP_SUM;
        state_next = S_SAT;
      end
      S_SAT: begin
        cmd.op = DP_SAT;
        if (!ch) begin
          ch_next    = 1'b1;
          state_next = S_MAG;
        end else begin
          state_next = S_PREP;
        end
      end
      S_PREP: begin
        cmd.op     = DP_PREP;
        idx_next   = '0;
        state_next = S_ROT;
      end
      S_ROT: begin
        cmd.op = DP_ROT;
        if (idx == IDX_W'(CORDIC_STEPS - 1)) begin
          ch_next    = 1'b0;
          state_next = S_GLO;
        end else begin
          idx_next = idx + IDX_W'(1);
        end
      end
      S_GLO: begin
        cmd.op     = DP_GLO;
        state_next = S_GHI;
      end
      S_GHI: begin
        cmd.op     = DP_GHI;
        state_next = S_GSUM;
      end
      S_GSUM: begin
        cmd.op     = DP_GSUM;
        state_next = S_GADD;
      end
      S_GADD: begin
        cmd.op = DP_GADD;
        if (!ch) begin
          ch_next    = 1'b1;
          state_next = S_GLO;
        end else begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        // wait until the output register is free
        if (!out_valid || m_tready) begin
          cmd.op         = DP_COMMIT;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = out_valid;

endmodule

@@ hdl/twio_dp.sv @@
// ----------------------------------------------------------------------------
// twio_dp
// odometry datapath: shared 33x33 multiplier, cordic rotator, position state
// ----------------------------------------------------------------------------
module twio_dp import twio_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  twio_cmd_t           cmd,
  output twio_status_t        status,
  input  logic [31:0]         length_per_degree,
  input  logic [31:0]         enc_a_deg,
  input  logic [31:0]         enc_b_deg,
  input  logic [31:0]         heading_in,
  input  logic                start_req,
  output logic [POS_W-1:0]    pos_x,
  output logic [POS_W-1:0]    pos_y,
  output logic [31:0]         heading_out
);

  // kept state
  logic [31:0]              last_enc_a, last_enc_b, heading_reg;
  logic signed [POS_W-1:0]  field_x, field_y;

  // per item working registers
  logic [31:0]              enc_a_q, enc_b_q, heading_q;
  logic                     start_q;
  logic [31:0]              delta_a, delta_b;
  logic [15:0]              phase;
  logic [32:0]              mag_u, mag_v;
  logic                     neg_u, neg_v;
  logic signed [65:0]       prod;
  logic [63:0]              plo;
  logic [MQ_W-1:0]          mq;
  logic [SUM_W-1:0]         body_sum;
  logic signed [XY_W-1:0]   cx, cy;
  logic signed [Z_W-1:0]    z;
  logic signed [D_W-1:0]    gdelta;

  // combinational
  logic [32:0]              hsum;
  logic signed [32:0]       da_s, db_s, u_s, v_s;
  logic [32:0]              mag_sel;
  logic                     neg_sel;
  logic signed [32:0]       mul_a, mul_b;
  logic [CAP_W-1:0]         body_mag;
  logic signed [XY_W-1:0]   body_ext, body_val;
  logic                     flip;
  logic signed [XY_W-1:0]   sx, sy, g_sel;
  logic signed [Z_W-1:0]    at;
  logic signed [POS_W-1:0]  f_sel, f_sat;
  logic signed [D_W:0]      fsum;

  assign hsum = {heading_reg[31], heading_reg} + {heading_in[31], heading_in};

  assign da_s = {delta_a[31], delta_a};
  assign db_s = {delta_b[31], delta_b};
  assign u_s  = da_s - db_s;
  assign v_s  = da_s + db_s;

  assign mag_sel = cmd.ch ? mag_v : mag_u;
  assign neg_sel = cmd.ch ? neg_v : neg_u;
  assign g_sel   = cmd.ch ? cy : cx;
  assign f_sel   = cmd.ch ? field_y : field_x;

  // operand selection of the shared multiplier
  always_comb begin
    case (cmd.op)
      DP_MAG: begin
        mul_a = {1'b0, mag_sel[31:0]};
        mul_b = 33'(C45);
      end
      DP_PLO: begin
        mul_a = {1'b0, mq[31:0]};
        mul_b = {1'b0, length_per_degree};
      end
      DP_PHI: begin
        mul_a = 33'(mq[MQ_W-1:32]);
        mul_b = {1'b0, length_per_degree};
      end
      DP_GLO: begin
        mul_a = {1'b0, g_sel[31:0]};
        mul_b = 33'(GAIN);
      end
      DP_GHI: begin
        mul_a = {{(33-(XY_W-32)){g_sel[XY_W-1]}}, g_sel[XY_W-1:32]};
        mul_b = 33'(GAIN);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // saturated body delta with its sign
  assign body_mag = (body_sum > SUM_W'(BODY_CAP)) ? BODY_CAP : body_sum[CAP_W-1:0];
  assign body_ext = {{(XY_W-CAP_W){1'b0}}, body_mag};
  assign body_val = neg_sel ? -body_ext : body_ext;

  // mean heading outside the right half plane turns by half a turn first
  assign flip = phase[15] ^ phase[14];

  assign sx = cx >>> cmd.idx;
  assign sy = cy >>> cmd.idx;
  assign at = Z_W'(twio_atan(5'(cmd.idx)));

  assign fsum = (D_W+1)'(f_sel) + (D_W+1)'(gdelta);
  always_comb begin
    if (&fsum[D_W:POS_W-1] || ~|fsum[D_W:POS_W-1]) begin
      f_sat = fsum[POS_W-1:0];
    end else if (fsum[D_W]) begin
      f_sat = {1'b1, {(POS_W-1){1'b0}}};
    end else begin
      f_sat = {1'b0, {(POS_W-1){1'b1}}};
    end
  end

  // kept state
  always_ff @(posedge clk) begin
    if (rst) begin
      last_enc_a  <= '0;
      last_enc_b  <= '0;
      heading_reg <= '0;
      field_x     <= '0;
      field_y     <= '0;
      start_q     <= 1'b0;
    end else begin
      if (cmd.op == DP_LOAD) begin
        start_q <= start_req;
      end
      if (cmd.op == DP_GADD) begin
        if (cmd.ch) begin
          field_y <= f_sat;
        end else begin
          field_x <= f_sat;
        end
      end
      if (cmd.op == DP_COMMIT) begin
        last_enc_a  <= enc_a_q;
        last_enc_b  <= enc_b_q;
        heading_reg <= heading_q;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      DP_LOAD: begin
        enc_a_q   <= enc_a_deg;
        enc_b_q   <= enc_b_deg;
        heading_q <= heading_in;
        delta_a   <= enc_a_deg - last_enc_a;
        delta_b   <= enc_b_deg - last_enc_b;
        phase     <= hsum[16:1];
      end
      DP_DIFF: begin
        neg_u <= u_s[32];
        neg_v <= v_s[32];
        mag_u <= u_s[32] ? 33'(-u_s) : 33'(u_s);
        mag_v <= v_s[32] ? 33'(-v_s) : 33'(v_s);
      end
      DP_MAG, DP_PLO, DP_GLO: begin
        prod <= mul_a * mul_b;
      end
      DP_PHI, DP_GHI: begin
        prod <= mul_a * mul_b;
        plo  <= prod[63:0];
      end
      DP_MQ: begin
        // a magnitude of exactly 2^32 has a zero low word
        mq <= mag_sel[32] ? MQ_W'({C45, 18'd0})
                          : MQ_W'((prod[63:0] + 64'd8192) >> 14);
      end
      DP_SUM: begin
        body_sum <= (SUM_W'(prod[MQ_W-1:0]) << UP) + SUM_W'(plo >> SH);
      end
      DP_SAT: begin
        if (cmd.ch) begin
          cy <= body_val;
        end else begin
          cx <= body_val;
        end
      end
      DP_PREP: begin
        if (flip) begin
          cx <= -cx;
          cy <= -cy;
        end
        z <= Z_W'($signed({phase[15] ^ flip, phase[14:0], 16'd0}));
      end
      DP_ROT: begin
        if (!z[Z_W-1]) begin
          cx <= cx - sy;
          cy <= cy + sx;
          z  <= z - at;
        end else begin
          cx <= cx + sy;
          cy <= cy - sx;
          z  <= z + at;
        end
      end
      DP_GSUM: begin
        gdelta <= D_W'((prod <<< GHI_UP) + $signed({1'b0, plo[63:GAIN_SH]}));
      end
      DP_COMMIT: begin
        pos_x       <= field_x;
        pos_y       <= field_y;
        heading_out <= heading_q;
      end
      default: begin
      end
    endcase
  end

  assign status.start = start_q;

endmodule

@@ hdl/two_wheel_imu_odometry.sv @@
// ----------------------------------------------------------------------------
// two_wheel_imu_odometry
// dead reckoning from two tracking wheels and an imu heading
// ----------------------------------------------------------------------------
//  port group  role            fields (lowest bits first)
//  s_*         item in         tdata: enc_a_deg, enc_b_deg, heading_in
//                              tuser: start_req
//  m_*         result out      tdata: pos_x, pos_y, heading_out
//  p*          register port   length_per_degree at byte address 0
//
//  a motion item uses the shared 33x33 multiplier (five uses per axis) for the
//  length scaling before the one-step-per-cycle cordic and the gain correction
//  after it; a start item goes from the difference step straight to the commit
//  s_tready is high only while idle; a waiting result sits in the output
//  register while the next item is accepted and worked on, held at its end
//  rst is synchronous and brings back zero state and the reset factor
// ----------------------------------------------------------------------------
module two_wheel_imu_odometry import twio_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // item in
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [95:0]           s_tdata,   // enc_a_deg, enc_b_deg, heading_in
  input  logic [0:0]            s_tuser,   // start_req
  // result out
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [127:0]          m_tdata,   // pos_x, pos_y, heading_out
  // register port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  logic [31:0]       length_per_degree;
  twio_cmd_t         cmd;
  twio_status_t      status;
  logic [POS_W-1:0]  pos_x, pos_y;
  logic [31:0]       heading_out;

  // register write on the access phase; low address bits are byte lanes
  always_ff @(posedge clk) begin
    if (rst) begin
      length_per_degree <= LPD_RESET;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[2] == REG_LPD_IDX)) begin
      length_per_degree <= pwdata;
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_LPD_IDX) ? length_per_degree : 32'd0;

  // sequencer
  twio_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // arithmetic and kept position
  twio_dp u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .status            (status),
    .length_per_degree (length_per_degree),
    .enc_a_deg         (s_tdata[31:0]),
    .enc_b_deg         (s_tdata[63:32]),
    .heading_in        (s_tdata[95:64]),
    .start_req         (s_tuser[0]),
    .pos_x             (pos_x),
    .pos_y             (pos_y),
    .heading_out       (heading_out)
  );

  assign m_tdata = {heading_out, pos_y, pos_x};

endmodule

@@ hdl/twio_checker.sv @@
// ----------------------------------------------------------------------------
// twio_checker
// port level checks of the odometry block
// ----------------------------------------------------------------------------
module twio_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [127:0] m_tdata
);

  // no result right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // one item at a time: no accept in the cycle after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("item accepted while busy");

  // a new result appears only at the end of work, never while idle
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(!s_tready))
    else $error("result without work");

  // a waiting result holds
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("waiting result changed");

endmodule

bind two_wheel_imu_odometry twio_checker u_twio_checker (.*);
